// ===== hdl/grm_pkg.sv =====
// Package for the grid ray march wall column core: item structs, codes,
// the quarter-wave sine table and the sine lookup functions.
// No dependencies.
package grm_pkg;

    localparam logic [1:0] KIND_CELL    = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_CAST    = 2'd2;

    localparam logic [1:0] HIT_WALL     = 2'd0;
    localparam logic [1:0] HIT_LEFT_MAP = 2'd1;
    localparam logic [1:0] HIT_NONE     = 2'd2;

    localparam logic [1:0] CFG_POS_X       = 2'd0;
    localparam logic [1:0] CFG_POS_Y       = 2'd1;
    localparam logic [1:0] CFG_STEP_LEN    = 2'd2;
    localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd3;

    localparam logic [7:0]  STEP_LEN_RESET    = 8'd20;
    localparam logic [10:0] VIEW_HEIGHT_RESET = 11'd512;
    localparam logic [11:0] HEIGHT_SAT        = 12'd4095;
    localparam logic [15:0] DIST_SAT          = 16'hFFFF;

    localparam logic [14:0] QUARTER_TABLE [33] = '{
        15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
        15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
        15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
        15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
        15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cell_index;
        logic [3:0]  cell_code;
        logic [3:0]  palette_index;
        logic [31:0] palette_color;
        logic [11:0] ray_angle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         hit_kind;
        logic [15:0]        distance;
        logic [3:0]         wall_code;
        logic [31:0]        wall_color;
        logic signed [11:0] wall_top;
        logic [11:0]        wall_height;
    } out_item_t;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [3:0] code;
    } map_wr_t;

    typedef struct packed {
        logic clearing;
        logic done;
    } march_stat_t;

    typedef struct packed {
        logic [1:0]  hit_kind;
        logic [15:0] distance;
        logic [3:0]  wall_code;
    } march_res_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } trig_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_TRIG,
        M_INC,
        M_RUN
    } march_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_MARCH,
        T_DIV,
        T_OUT
    } core_state_t;

    function automatic logic [14:0] quarter_sine(input logic [10:0] q);
        logic [4:0]  k;
        logic [4:0]  f;
        logic [14:0] t0;
        logic [14:0] t1;
        logic [9:0]  dlt;
        logic [14:0] prod;
        logic [14:0] val;
        k    = q[9:5];
        f    = q[4:0];
        t0   = QUARTER_TABLE[{1'b0, k}];
        t1   = QUARTER_TABLE[{1'b0, k} + 6'd1];
        dlt  = 10'(t1 - t0);
        prod = {5'd0, dlt} * {10'd0, f};
        if (q[10]) begin
            val = 15'd16384;
        end else begin
            val = t0 + {5'd0, prod[14:5]};
        end
        return val;
    endfunction

    function automatic trig_t binary_sine(input logic [11:0] a);
        logic [10:0] q;
        trig_t       t;
        q     = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
        t.mag = quarter_sine(q);
        t.neg = a[11] && (t.mag != 15'd0);
        return t;
    endfunction

endpackage

// ===== hdl/grm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the wall column height.
// Depends on nothing but its ports.
module grm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [21:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [21:0] quotient
);

    localparam logic [4:0] LAST_BIT = 5'd21;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [21:0] quo_reg;
    logic [15:0] dvs_reg;

    logic [16:0] trial;
    logic        ge;
    logic [16:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[21]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_BIT);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next[15:0];
            quo_reg <= {quo_reg[20:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/grm_march.sv =====
// Ray march engine: wall map memory with its clearing pass, sine setup and
// the step pipeline (point, map read, resolve). Uses grm_pkg.
module grm_march import grm_pkg::*; #(
    parameter int GRID_SIDE = 16,
    parameter int MAX_STEPS = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  map_wr_t     map_wr,
    input  logic        start,
    input  logic [11:0] ray_angle,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  step_len,
    output march_stat_t stat,
    output march_res_t  res
);

    localparam int MAP_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int MAP_AW    = $clog2(MAP_CELLS);
    localparam int COL_W     = $clog2(GRID_SIDE);
    localparam int N_W       = $clog2(MAX_STEPS);
    localparam int LEN_W     = (N_W + 8 > 17) ? N_W + 8 : 17;
    localparam int M_W       = LEN_W + 15;
    localparam int OFF_W     = M_W - 14;
    localparam int P_W       = LEN_W + 3;
    localparam logic [M_W-1:0] NEG_BIAS = M_W'(16383);

    logic [3:0] map_mem [MAP_CELLS];

    march_state_t state_reg, state_next;
    logic do_trig, do_inc, run;

    logic              clr_reg;
    logic [MAP_AW-1:0] clr_cnt_reg;
    logic [11:0]       angle_reg;
    trig_t             sin_reg, cos_reg;
    logic [22:0]       incx_reg, incy_reg;
    logic [M_W-1:0]    mx_reg, my_reg;
    logic [LEN_W-1:0]  len_reg, maxlen_reg;
    logic [N_W-1:0]    n_reg;
    logic              issue_reg;

    logic [P_W-1:0]    px_reg, py_reg;
    logic [LEN_W-1:0]  lenp_reg;
    logic              lastp_reg, validp_reg;

    logic [3:0]        rd_reg;
    logic              oobb_reg, lastb_reg, validb_reg;
    logic [LEN_W-1:0]  lenb_reg;

    march_res_t        res_reg, res_next;
    logic              done_reg;

    logic [OFF_W-1:0]  off_x, off_y;
    logic [P_W-1:0]    px_a, py_a;
    logic              last_a;
    logic              oob_p;
    logic [COL_W-1:0]  col_p, row_p;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [3:0]        wr_code;
    logic              finish;
    logic [LEN_W-1:0]  len_sel;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: begin
                if (start) begin
                    state_next = M_TRIG;
                end
            end
            M_TRIG:  state_next = M_INC;
            M_INC:   state_next = M_RUN;
            M_RUN: begin
                if (finish) begin
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_comb begin
        do_trig = 1'b0;
        do_inc  = 1'b0;
        run     = 1'b0;
        case (state_reg)
            M_TRIG:  do_trig = 1'b1;
            M_INC:   do_inc  = 1'b1;
            M_RUN:   run     = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        off_x  = mx_reg[M_W-1:14];
        off_y  = my_reg[M_W-1:14];
        px_a   = cos_reg.neg ? (P_W'(pos_x) - P_W'(off_x)) : (P_W'(pos_x) + P_W'(off_x));
        py_a   = sin_reg.neg ? (P_W'(pos_y) - P_W'(off_y)) : (P_W'(pos_y) + P_W'(off_y));
        last_a = n_reg == N_W'(MAX_STEPS - 1);

        oob_p = px_reg[P_W-1] || py_reg[P_W-1] ||
                ({7'd0, px_reg[P_W-2:11]} >= (P_W-5)'(GRID_SIDE)) ||
                ({7'd0, py_reg[P_W-2:11]} >= (P_W-5)'(GRID_SIDE));
        col_p   = px_reg[11+COL_W-1:11];
        row_p   = py_reg[11+COL_W-1:11];
        rd_addr = MAP_AW'(col_p) + MAP_AW'(MAP_AW'(row_p) * MAP_AW'(GRID_SIDE));

        wr_en   = clr_reg || (map_wr.en && ({24'd0, map_wr.index} < 32'(MAP_CELLS)));
        wr_addr = clr_reg ? clr_cnt_reg : MAP_AW'(map_wr.index);
        wr_code = clr_reg ? 4'd0 : map_wr.code;

        finish = run && validb_reg && (oobb_reg || (rd_reg != 4'd0) || lastb_reg);

        if (oobb_reg) begin
            res_next.hit_kind  = HIT_LEFT_MAP;
            res_next.wall_code = 4'd0;
            len_sel            = lenb_reg;
        end else if (rd_reg != 4'd0) begin
            res_next.hit_kind  = HIT_WALL;
            res_next.wall_code = rd_reg;
            len_sel            = lenb_reg;
        end else begin
            res_next.hit_kind  = HIT_NONE;
            res_next.wall_code = 4'd0;
            len_sel            = maxlen_reg;
        end
        res_next.distance = (|len_sel[LEN_W-1:16]) ? DIST_SAT : len_sel[15:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_code;
        end
        rd_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= M_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            issue_reg   <= 1'b0;
            validp_reg  <= 1'b0;
            validb_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + MAP_AW'(1);
                if (clr_cnt_reg == MAP_AW'(MAP_CELLS - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            done_reg <= finish;
            if (do_inc) begin
                issue_reg <= 1'b1;
            end else if (finish || (issue_reg && last_a)) begin
                issue_reg <= 1'b0;
            end
            validp_reg <= run && issue_reg && !finish;
            validb_reg <= run && validp_reg && !finish;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == M_IDLE)) begin
            angle_reg <= ray_angle;
        end
        if (do_trig) begin
            sin_reg <= binary_sine(angle_reg);
            cos_reg <= binary_sine(angle_reg + 12'd1024);
        end
        if (do_inc) begin
            incx_reg   <= {15'd0, step_len} * {8'd0, cos_reg.mag};
            incy_reg   <= {15'd0, step_len} * {8'd0, sin_reg.mag};
            mx_reg     <= cos_reg.neg ? NEG_BIAS : '0;
            my_reg     <= sin_reg.neg ? NEG_BIAS : '0;
            len_reg    <= '0;
            n_reg      <= '0;
            maxlen_reg <= LEN_W'(step_len) * LEN_W'(MAX_STEPS);
        end else if (run && issue_reg) begin
            mx_reg  <= mx_reg + M_W'(incx_reg);
            my_reg  <= my_reg + M_W'(incy_reg);
            len_reg <= len_reg + LEN_W'(step_len);
            n_reg   <= n_reg + N_W'(1);
        end
        if (run && issue_reg) begin
            px_reg    <= px_a;
            py_reg    <= py_a;
            lenp_reg  <= len_reg;
            lastp_reg <= last_a;
        end
        oobb_reg  <= oob_p;
        lenb_reg  <= lenp_reg;
        lastb_reg <= lastp_reg;
        if (finish) begin
            res_reg <= res_next;
        end
    end

    assign stat.clearing = clr_reg;
    assign stat.done     = done_reg;
    assign res           = res_reg;

`ifndef SYNTHESIS
    a_resolve_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        validb_reg |-> state_reg == M_RUN)
        else $error("map read result pending outside the march");
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_reg |=> !clr_reg)
        else $error("clearing pass restarted without reset");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> state_reg == M_IDLE && !validb_reg)
        else $error("march reported done while still running");
`endif

endmodule

// ===== hdl/grid_ray_march_wall_column_core.sv =====
// Top level of the grid ray march wall column core: configuration registers,
// palette memory, sequencing and output register. Uses grm_pkg, grm_march, grm_div.
//
//   channel  ports                                   carries
//   input    s_valid, s_ready, s_data             in_item_t: map write, palette write, cast
//   result   m_valid, m_ready, m_data             out_item_t: one per cast
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data   register writes, always ready
//
// A cast does one map read per march step in the march pipeline, with at most
// MAX_STEPS steps, plus sine setup, pipeline drain and the divider.
// After reset a clearing pass zeroes all GRID_SIDE * GRID_SIDE cells of the wall
// map; no transaction is taken on the input channel until it ends.
// A stalled result transaction holds the finished item in the output register; a
// following cast waits in T_OUT, with s_ready low, until the result is taken.
module grid_ray_march_wall_column_core import grm_pkg::*; #(
    parameter int GRID_SIDE     = 16,
    parameter int MAX_STEPS     = 2048,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [31:0] pal_mem [PALETTE_DEPTH];

    core_state_t state_reg, state_next;

    logic [15:0] pos_x_reg, pos_y_reg;
    logic [7:0]  step_len_reg;
    logic [10:0] view_height_reg;

    logic        s_accept;
    logic        cast_start;
    logic        pal_wr;
    map_wr_t     map_wr;
    march_stat_t mstat;
    march_res_t  mres;
    march_res_t  res_reg;
    logic [31:0] pal_rd_reg;

    logic        div_start;
    logic        div_done;
    logic [21:0] quotient;

    logic        out_load;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    out_item_t   out_next;
    logic        color_ok;
    logic [11:0] height;
    logic [12:0] diff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            step_len_reg    <= STEP_LEN_RESET;
            view_height_reg <= VIEW_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_POS_X:       pos_x_reg       <= cfg_data;
                CFG_POS_Y:       pos_y_reg       <= cfg_data;
                CFG_STEP_LEN:    step_len_reg    <= cfg_data[7:0];
                CFG_VIEW_HEIGHT: view_height_reg <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (cast_start) begin
                    state_next = T_MARCH;
                end
            end
            T_MARCH: begin
                if (mstat.done) begin
                    state_next = T_DIV;
                end
            end
            T_DIV: begin
                if (div_done) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (out_load) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            T_IDLE:  s_ready   = !mstat.clearing;
            T_MARCH: div_start = mstat.done;
            T_OUT:   out_load  = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_comb begin
        s_accept     = s_valid && s_ready;
        cast_start   = s_accept && (s_data.kind == KIND_CAST);
        map_wr.en    = s_accept && (s_data.kind == KIND_CELL);
        map_wr.index = s_data.cell_index;
        map_wr.code  = s_data.cell_code;
        pal_wr       = s_accept && (s_data.kind == KIND_PALETTE) &&
                       (9'(s_data.palette_index) < 9'(PALETTE_DEPTH));

        color_ok = (res_reg.hit_kind == HIT_WALL) &&
                   (9'(res_reg.wall_code) < 9'(PALETTE_DEPTH));
        if ((res_reg.distance == 16'd0) || (|quotient[21:12])) begin
            height = HEIGHT_SAT;
        end else begin
            height = quotient[11:0];
        end
        diff = {2'b00, view_height_reg} - {1'b0, height};

        out_next.hit_kind    = res_reg.hit_kind;
        out_next.distance    = res_reg.distance;
        out_next.wall_code   = res_reg.wall_code;
        out_next.wall_color  = color_ok ? pal_rd_reg : 32'd0;
        out_next.wall_top    = diff[12:1];
        out_next.wall_height = height;
    end

    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[PAL_AW'(s_data.palette_index)] <= s_data.palette_color;
        end
        pal_rd_reg <= pal_mem[PAL_AW'(res_reg.wall_code)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mstat.done) begin
            res_reg <= mres;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    grm_march #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_STEPS (MAX_STEPS)
    ) u_march (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .map_wr    (map_wr),
        .start     (cast_start),
        .ray_angle (s_data.ray_angle),
        .pos_x     (pos_x_reg),
        .pos_y     (pos_y_reg),
        .step_len  (step_len_reg),
        .stat      (mstat),
        .res       (mres)
    );

    grm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({view_height_reg, 11'd0}),
        .divisor  (mres.distance),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_done_in_march: assert property (@(posedge aclk) disable iff (!aresetn)
        mstat.done |-> state_reg == T_MARCH)
        else $error("march result arrived with no cast in flight");
    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.hit_kind != HIT_WALL) |->
            (m_data_reg.wall_code == 4'd0) && (m_data_reg.wall_color == 32'd0))
        else $error("non-wall result carries a wall code or color");
`endif

endmodule
